// ===== design/amv_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC moving average package
// Shared widths, register indexes, reset values and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package amv_pkg;

    localparam int RAW_W      = 12;
    localparam int FS_W       = 16;
    localparam int MAX_W      = 12;
    localparam int MV_W       = 16;
    localparam int PROD_W     = RAW_W + FS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_MAX    = 2'd1;

    localparam logic [FS_W-1:0]  FS_RESET  = 16'd3300;
    localparam logic [MAX_W-1:0] MAX_RESET = 12'd4095;

    typedef struct packed {
        logic ld_in;        // capture the accepted input transaction
        logic mul;          // form raw times full scale, read the oldest entry
        logic div_start;    // start the shared divider
        logic div_sel_avg;  // divider operands: 1 = sum by count, 0 = scaling
        logic ld_mv;        // take the scaled value from the divider
        logic update;       // write the window, sum, position and count
        logic ld_out;       // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic ok;           // captured conversion succeeded
        logic sat;          // captured sample saturates to full scale
        logic div_done;     // divider holds a finished quotient
    } t_dp_sts;

endpackage

// ===== design/amv_divider.sv =====
// ----------------------------------------------------------------------------
// ADC moving average divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module amv_divider #(
    parameter int DVD_W = 28,
    parameter int DVS_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;

    logic [DVS_W:0]   w_shift;
    logic [DVS_W+1:0] w_diff;

    always_comb begin
        w_shift = {r_rem, r_quo[DVD_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
        n_busy  = r_busy;
        n_done  = r_done;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = CW'(DVD_W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // A borrow means the shifted remainder is below the divisor.
            if (!w_diff[DVS_W+1]) begin
                n_rem = w_diff[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/amv_datapath.sv =====
// ----------------------------------------------------------------------------
// ADC moving average datapath
// Configuration registers, scaling multiplier, window memory, running sum and
// the shared divider, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module amv_datapath #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [amv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [amv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [amv_pkg::RAW_W-1:0]      i_raw_sample,
    input  logic                           i_conversion_ok,
    input  amv_pkg::t_dp_cmd               i_cmd,
    output amv_pkg::t_dp_sts               o_sts,
    output logic [amv_pkg::MV_W-1:0]       o_voltage_mv
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W = $clog2(WINDOW_DEPTH * ((1 << amv_pkg::MV_W) - 1) + 1);
    localparam int DVD_W = (SUM_W > amv_pkg::PROD_W) ? SUM_W : amv_pkg::PROD_W;
    localparam int DVS_W = (CNT_W > amv_pkg::MAX_W) ? CNT_W : amv_pkg::MAX_W;
    localparam logic [CNT_W-1:0] FULL     = CNT_W'(WINDOW_DEPTH);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_DEPTH - 1);

    logic [amv_pkg::FS_W-1:0]   r_fs;
    logic [amv_pkg::MAX_W-1:0]  r_max;
    logic [amv_pkg::RAW_W-1:0]  r_raw;
    logic                       r_ok;
    logic [amv_pkg::PROD_W-1:0] r_prod;
    logic [amv_pkg::MV_W-1:0]   r_mv;
    logic [amv_pkg::MV_W-1:0]   r_old;
    logic [amv_pkg::MV_W-1:0]   r_out;
    logic [SUM_W-1:0]           r_sum, n_sum;
    logic [POS_W-1:0]           r_pos, n_pos;
    logic [CNT_W-1:0]           r_fill, n_fill;
    logic [amv_pkg::MV_W-1:0]   r_mem [WINDOW_DEPTH];

    logic                       w_sat;
    logic [amv_pkg::MV_W-1:0]   w_old;
    logic [DVD_W-1:0]           w_dvd;
    logic [DVS_W-1:0]           w_dvs;
    logic                       w_div_done;
    logic [DVD_W-1:0]           w_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs  <= amv_pkg::FS_RESET;
            r_max <= amv_pkg::MAX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                amv_pkg::REG_FULL_SCALE: r_fs  <= i_cfg_data[amv_pkg::FS_W-1:0];
                amv_pkg::REG_ADC_MAX:    r_max <= i_cfg_data[amv_pkg::MAX_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero maximum code makes every sample count as above the maximum.
    assign w_sat = (r_max == '0) || (r_raw > r_max);

    // Slots at or past the fill count were never written and are read as zero.
    assign w_old = (r_fill == FULL) ? r_old : '0;

    always_comb begin
        n_sum  = r_sum - SUM_W'(w_old) + SUM_W'(r_mv);
        n_pos  = (r_pos == LAST_POS) ? '0 : r_pos + POS_W'(1);
        n_fill = (r_fill == FULL) ? r_fill : r_fill + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_pos  <= '0;
            r_fill <= '0;
        end else if (i_cmd.update) begin
            r_sum  <= n_sum;
            r_pos  <= n_pos;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_raw <= i_raw_sample;
            r_ok  <= i_conversion_ok;
        end
        if (i_cmd.mul) begin
            r_prod <= {{amv_pkg::FS_W{1'b0}}, r_raw} * {{amv_pkg::RAW_W{1'b0}}, r_fs};
            if (w_sat) begin
                r_mv <= r_fs;
            end
        end
        if (i_cmd.ld_mv) begin
            r_mv <= w_quo[amv_pkg::MV_W-1:0];
        end
        if (i_cmd.ld_out) begin
            r_out <= r_ok ? w_quo[amv_pkg::MV_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_old <= r_mem[r_pos];
        end
        if (i_cmd.update) begin
            r_mem[r_pos] <= r_mv;
        end
    end

    assign w_dvd = i_cmd.div_sel_avg ? DVD_W'(r_sum) : DVD_W'(r_prod);
    assign w_dvs = i_cmd.div_sel_avg ? DVS_W'(r_fill) : DVS_W'(r_max);

    amv_divider #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign o_sts.ok       = r_ok;
    assign o_sts.sat      = w_sat;
    assign o_sts.div_done = w_div_done;
    assign o_voltage_mv   = r_out;

    a_empty_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_sum == '0))
        else $error("running sum is nonzero while the window is empty");

    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && (r_fill != FULL)) |=> (r_fill == $past(r_fill) + CNT_W'(1)))
        else $error("fill count did not grow by one on a window update");

    a_pos_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && (r_pos == LAST_POS)) |=> (r_pos == '0))
        else $error("write position did not wrap at the end of the window");

    a_div_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> !w_div_done)
        else $error("divider reports done right after a start");

endmodule

// ===== design/amv_controller.sv =====
// ----------------------------------------------------------------------------
// ADC moving average controller
// Sequences one transaction through scaling, window update and averaging,
// and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module amv_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output amv_pkg::t_dp_cmd o_cmd,
    input  amv_pkg::t_dp_sts i_sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DSCALE = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_ASTART = 3'd5;
    localparam logic [2:0] S_ADIV   = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                if (!i_sts.ok) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = i_sts.sat ? S_UPDATE : S_DSTART;
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DSCALE;
            end
            S_DSCALE: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_mv = 1'b1;
                    n_state     = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_ASTART;
            end
            S_ASTART: begin
                o_cmd.div_start   = 1'b1;
                o_cmd.div_sel_avg = 1'b1;
                n_state           = S_ADIV;
            end
            S_ADIV: begin
                o_cmd.div_sel_avg = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.ld_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_out_not_overwritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_out |-> (!r_out_valid || i_out_ready))
        else $error("output register loaded while a result is still held");

    a_fail_skips_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && !i_sts.ok) |=> (r_state == S_OUT && !$past(o_cmd.mul)))
        else $error("failed conversion entered the datapath");

    a_avg_done_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADIV && i_sts.div_done) |=> (r_state == S_OUT))
        else $error("finished average did not move to the output state");

endmodule

// ===== design/adc_voltage_moving_average_unit.sv =====
// ----------------------------------------------------------------------------
// ADC voltage moving average unit
// Scales ADC conversions to millivolts and reports the moving average over
// the last WINDOW_DEPTH successful conversions.
// ----------------------------------------------------------------------------
// One input transaction is taken at a time and gives exactly one result. A
// successful conversion is scaled as raw times full_scale_mv divided by
// adc_max_code (a raw code above the maximum, or a zero maximum, gives full
// scale), written into the ring window, and the result is the running sum
// divided by the number of values held so far. A failed conversion gives 0
// and leaves the window alone. Both divisions run on one shared restoring
// divider that retires one quotient bit per cycle; its width D is the larger
// of 28 and the running sum width, which is 20 at the default depth of 16,
// so D is 28 there. An ordinary sample runs the scaling division and then
// the averaging division before the next ready, a saturated sample skips
// the scaling division, and a failed conversion goes straight to output. The
// result sits in an output register, so a new transaction is accepted while
// the previous result waits to be taken. The window is a memory with a
// registered read; entries never written read as zero through the fill
// count, so no clearing pass is needed after reset. The configuration port
// is always ready, and writes to indexes other than the two registers are
// ignored; configuration should only be written while the unit is idle.
// ----------------------------------------------------------------------------
module adc_voltage_moving_average_unit #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [amv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [amv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel: one ADC conversion per transaction.
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [amv_pkg::RAW_W-1:0]      i_raw_sample,
    input  logic                           i_conversion_ok,
    // Output channel: one averaged voltage per transaction.
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [amv_pkg::MV_W-1:0]       o_voltage_mv
);

    amv_pkg::t_dp_cmd w_cmd;
    amv_pkg::t_dp_sts w_sts;

    // Register writes are plain register loads, so the port never stalls.
    assign o_cfg_ready = 1'b1;

    amv_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    amv_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_raw_sample    (i_raw_sample),
        .i_conversion_ok (i_conversion_ok),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_voltage_mv    (o_voltage_mv)
    );

endmodule

// ===== test/adc_voltage_moving_average_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC voltage moving average unit testbench
// Drives ADC conversions and register writes into the unit and checks every
// averaged voltage against an in-bench predictor of the scaling, the ring
// window and the running average, under random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module adc_voltage_moving_average_unit_test;

    localparam int WINDOW = 16;

    // Indexes beyond the two real registers. Writes to them must be ignored.
    localparam logic [amv_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [amv_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int PHASES          = 10;
    localparam int PHASE_ITEMS     = 153;
    // The unit is idle once the last result is taken, so a settle of
    // SETTLE_CYCLES is plenty before the registers are touched.
    localparam int SETTLE_CYCLES   = 8;
    localparam int END_CYCLES      = 100;
    // Cycles without any transaction before the run is declared hung. The
    // longest legal quiet stretch is the receiver hold-off of HOLD_CYCLES.
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_CYCLES     = 600;
    localparam int HOLD_AFTER      = 300;

    typedef struct packed {
        logic [amv_pkg::RAW_W-1:0] raw;
        logic                      ok;
    } t_conversion;

    typedef struct packed {
        logic [amv_pkg::MV_W-1:0]  mv;
        logic [amv_pkg::RAW_W-1:0] raw;
        logic                      ok;
    } t_voltage;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the unit. Every input starts at a known
    // value so nothing floats while reset is held.
    // ------------------------------------------------------------------------
    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_cfg_valid     = 1'b0;
    logic                           o_cfg_ready;
    logic [amv_pkg::CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [amv_pkg::CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                           i_in_valid      = 1'b0;
    logic                           o_in_ready;
    logic [amv_pkg::RAW_W-1:0]      i_raw_sample    = '0;
    logic                           i_conversion_ok = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_ready     = 1'b0;
    logic [amv_pkg::MV_W-1:0]       o_voltage_mv;

    always #5 i_clk = ~i_clk;

    adc_voltage_moving_average_unit #(
        .WINDOW_DEPTH(WINDOW)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_raw_sample   (i_raw_sample),
        .i_conversion_ok(i_conversion_ok),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_voltage_mv   (o_voltage_mv)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the two registers and of the ring
    // window. It advances only on transactions seen at the rising edge.
    // ------------------------------------------------------------------------
    logic [amv_pkg::FS_W-1:0]  full_scale_mv = amv_pkg::FS_RESET;
    logic [amv_pkg::MAX_W-1:0] adc_max_code  = amv_pkg::MAX_RESET;
    logic [amv_pkg::MV_W-1:0]  window_mv [WINDOW];
    int unsigned               window_sum    = 0;
    int unsigned               next_slot     = 0;
    int unsigned               held_count    = 0;

    t_conversion pending_conversions[$];
    t_voltage    expected_voltages[$];

    // Run statistics and the error tally.
    int error_count      = 0;
    int accepted_count   = 0;
    int failed_count     = 0;
    int saturated_count  = 0;
    int checked_count    = 0;
    int register_writes  = 0;

    // Set by the monitor at each rising edge; the driver reads it at the
    // following falling edge to learn whether its item went in.
    logic in_fire = 1'b0;

    initial begin
        for (int k = 0; k < WINDOW; k++) begin
            window_mv[k] = '0;
        end
    end

    // Millivolts for one raw code under the current registers. A zero maximum
    // code or a raw code above it saturates to full scale.
    function automatic logic [amv_pkg::MV_W-1:0] scale_to_mv(
            logic [amv_pkg::RAW_W-1:0] raw);
        int unsigned product;
        if (adc_max_code == '0 || raw > adc_max_code) begin
            saturated_count++;
            return full_scale_mv;
        end
        product = int'(raw) * int'(full_scale_mv);
        return amv_pkg::MV_W'(product / int'(adc_max_code));
    endfunction

    // Pushes one successful conversion into the window and returns the new
    // average. A failed conversion leaves the window alone and gives 0.
    function automatic logic [amv_pkg::MV_W-1:0] average_after(t_conversion conv);
        logic [amv_pkg::MV_W-1:0] mv;
        if (!conv.ok) begin
            failed_count++;
            return '0;
        end
        mv = scale_to_mv(conv.raw);
        window_sum = window_sum - 32'(window_mv[next_slot]) + 32'(mv);
        window_mv[next_slot] = mv;
        next_slot = (next_slot + 1) % WINDOW;
        if (held_count < WINDOW) begin
            held_count++;
        end
        return amv_pkg::MV_W'(window_sum / held_count);
    endfunction

    function automatic void apply_register(logic [amv_pkg::CFG_IDX_W-1:0] idx,
                                           logic [amv_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            amv_pkg::REG_FULL_SCALE: begin
                full_scale_mv = data[amv_pkg::FS_W-1:0];
            end
            amv_pkg::REG_ADC_MAX: begin
                adc_max_code = data[amv_pkg::MAX_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: register writes, accepted conversions and results are all
    // taken at the rising edge, before the unit's own updates land.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_voltage want;
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
                register_writes++;
            end
            if (in_fire) begin
                want.raw = i_raw_sample;
                want.ok  = i_conversion_ok;
                want.mv  = average_after('{raw: i_raw_sample, ok: i_conversion_ok});
                expected_voltages.push_back(want);
                accepted_count++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_voltages.size() == 0) begin
                    $display("%0t: result %0d arrived with no conversion pending",
                             $realtime, o_voltage_mv);
                    error_count++;
                end else begin
                    want = expected_voltages.pop_front();
                    checked_count++;
                    if (o_voltage_mv !== want.mv) begin
                        $display({"%0t: voltage_mv mismatch (raw %0d ok %0b)",
                                  " expected %0d actual %0d"},
                                 $realtime, want.raw, want.ok, want.mv, o_voltage_mv);
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: offers pending conversions in bursts separated by random gaps.
    // A gap only starts after a transaction, so valid never drops early.
    // Gaps are random in length so that new items land on every stage of the
    // unit's work.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        t_conversion conv;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_conversions.size() > 0) begin
                conv = pending_conversions.pop_front();
                i_raw_sample    <= conv.raw;
                i_conversion_ok <= conv.ok;
                i_in_valid      <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switches between always ready, coin-flip ready and mostly
    // stalled. Once, after a few hundred results, it holds off completely for
    // a long stretch so the output register fills and the input backs up
    // while the driver keeps offering.
    // ------------------------------------------------------------------------
    int  ready_mode = 0;
    int  mode_left  = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;

    always @(negedge i_clk) begin
        if (!hold_done && checked_count >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 400);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                default: i_out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any transaction on any channel resets the quiet counter.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $realtime, WATCHDOG_LIMIT, expected_voltages.size());
            $display("adc_voltage_moving_average_unit_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing helpers.
    // ------------------------------------------------------------------------

    // Returns once every queued conversion has gone in and every result has
    // come back. Checked at the rising edge, where the answer can only err on
    // the side of waiting longer than needed.
    task automatic wait_until_idle();
        do begin
            @(posedge i_clk);
        end while (pending_conversions.size() != 0 || i_in_valid ||
                   expected_voltages.size() != 0);
    endtask

    // One register write. Valid stays high across back-to-back writes; the
    // caller drops it after the last one.
    task automatic write_register(logic [amv_pkg::CFG_IDX_W-1:0] idx,
                                  logic [amv_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
    endtask

    // Random conversion aimed at the interesting codes for the current
    // maximum: zero, all ones, exactly the maximum, just above it, just
    // below it, and a uniform spread. About one in ten times out.
    function automatic t_conversion random_conversion();
        t_conversion conv;
        int unsigned top;
        top = 32'(adc_max_code);
        case ($urandom_range(0, 9))
            0: conv.raw = '0;
            1: conv.raw = '1;
            2: conv.raw = amv_pkg::RAW_W'(top);
            3: conv.raw = (top < 4095) ? amv_pkg::RAW_W'(top + 1)
                                       : amv_pkg::RAW_W'($urandom_range(0, 4095));
            4: conv.raw = amv_pkg::RAW_W'($urandom_range((top > 8) ? top - 8 : 0, top));
            default: conv.raw = amv_pkg::RAW_W'($urandom_range(0, 4095));
        endcase
        conv.ok = ($urandom_range(0, 9) != 0);
        return conv;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus: reset, a directed opening under the reset registers, then a
    // series of register settings each followed by a block of random
    // conversions. The window is never cleared between settings, so old
    // entries scaled under one setting age out under the next.
    // ------------------------------------------------------------------------
    logic [amv_pkg::FS_W-1:0]  phase_full_scale [PHASES];
    logic [amv_pkg::MAX_W-1:0] phase_max_code   [PHASES];

    initial begin
        phase_full_scale = '{16'hFFFF, 16'd1, 16'd0, 16'd5000, 16'hFFFF,
                             amv_pkg::FS_RESET, 16'd0, 16'd0, 16'd0, 16'd0};
        phase_max_code   = '{12'd1, 12'hFFF, 12'hFFF, 12'd0, 12'hFFF,
                             amv_pkg::MAX_RESET, 12'd0, 12'd0, 12'd0, 12'd0};
        // The last four settings are random.
        for (int p = 6; p < PHASES; p++) begin
            phase_full_scale[p] = amv_pkg::FS_W'($urandom_range(1, 65535));
            phase_max_code[p]   = amv_pkg::MAX_W'($urandom_range(1, 4095));
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: a failed conversion on an empty window, the code
        // extremes and alternating bit patterns, a timeout carrying all ones,
        // then enough good samples to fill the window and wrap it, with a
        // timeout in between that must leave the window untouched.
        pending_conversions.push_back('{raw: 12'd0,    ok: 1'b0});
        pending_conversions.push_back('{raw: 12'd0,    ok: 1'b1});
        pending_conversions.push_back('{raw: 12'hFFF,  ok: 1'b1});
        pending_conversions.push_back('{raw: 12'hFFE,  ok: 1'b1});
        pending_conversions.push_back('{raw: 12'd1,    ok: 1'b1});
        pending_conversions.push_back('{raw: 12'hAAA,  ok: 1'b1});
        pending_conversions.push_back('{raw: 12'h555,  ok: 1'b1});
        pending_conversions.push_back('{raw: 12'hFFF,  ok: 1'b0});
        for (int k = 0; k < 11; k++) begin
            pending_conversions.push_back('{raw: amv_pkg::RAW_W'(k * 409), ok: 1'b1});
        end
        pending_conversions.push_back('{raw: 12'h7FF,  ok: 1'b0});
        pending_conversions.push_back('{raw: 12'h800,  ok: 1'b1});

        for (int p = 0; p < PHASES; p++) begin
            wait_until_idle();
            repeat (SETTLE_CYCLES) @(posedge i_clk);

            // Writes to the unused indexes go first so that, if they were
            // wrongly decoded, the real writes below would not hide it.
            if (p % 3 == 2) begin
                write_register(REG_SPARE_A,
                               amv_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
                write_register(REG_SPARE_B,
                               amv_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
            end
            write_register(amv_pkg::REG_FULL_SCALE, phase_full_scale[p]);
            // Bits above the 12-bit maximum carry random junk.
            write_register(amv_pkg::REG_ADC_MAX,
                           {4'($urandom_range(0, 15)), phase_max_code[p]});
            if (p == 5) begin
                // Unused indexes written after the real registers as well.
                write_register(REG_SPARE_A, 16'h0000);
                write_register(REG_SPARE_B, 16'hFFFF);
            end
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pending_conversions.push_back(random_conversion());
            end
        end

        wait_until_idle();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Covered %0d conversions (%0d timed out, %0d saturated) over %0d settings,",
                 accepted_count, failed_count, saturated_count, PHASES + 1);
        $display("%0d results checked, %0d register writes, %0d mismatches.",
                 checked_count, register_writes, error_count);
        if (error_count == 0) begin
            $display("adc_voltage_moving_average_unit_test: clean");
        end else begin
            $display("adc_voltage_moving_average_unit_test: errors");
        end
        $finish;
    end

endmodule

// ===== adc_voltage_moving_average_unit.f =====
design/amv_pkg.sv
design/amv_divider.sv
design/amv_datapath.sv
design/amv_controller.sv
design/adc_voltage_moving_average_unit.sv
test/adc_voltage_moving_average_unit_test.sv
